[hw/rtl/mneu_pkg.sv]
// ----------------------------------------------------------------------------
// mneu_pkg
// Shared types and constants for the MIDI note event encoder.
// ----------------------------------------------------------------------------
package mneu_pkg;

  localparam int DeltaW    = 28;
  localparam int GroupW    = 7;
  localparam int MaxDelta  = 4;
  localparam int NDeltaW   = 3;

  localparam logic [7:0] StatusOff = 8'h80;
  localparam logic [7:0] StatusOn  = 8'h90;

  typedef struct packed {
    logic [NDeltaW-1:0] n_delta;
    logic [DeltaW-1:0]  delta;
    logic [7:0]         status;
    logic [7:0]         key;
    logic [6:0]         vel;
  } desc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_STATUS,
    ST_KEY,
    ST_VEL
  } state_t;

endpackage

[hw/rtl/mneu_front.sv]
// ----------------------------------------------------------------------------
// mneu_front
// Accepts note events, sizes the delta VLQ and forms status and key bytes.
// ----------------------------------------------------------------------------
module mneu_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic signed [28:0]   in_delta_ticks,
  input  logic [3:0]           in_channel,
  input  logic [4:0]           in_octave,
  input  logic [3:0]           in_pitch_class,
  input  logic [6:0]           in_velocity,
  input  logic                 q_full,
  output logic                 q_push,
  output mneu_pkg::desc_t      q_desc
);

  logic [mneu_pkg::DeltaW-1:0]  mag;
  logic [mneu_pkg::NDeltaW-1:0] n_delta;
  logic [8:0]                   key_sum;

  assign mag = in_delta_ticks[mneu_pkg::DeltaW-1:0];

  always_comb begin
    priority if (in_delta_ticks[28]) begin
      n_delta = 3'd0;
    end else if (|mag[27:21]) begin
      n_delta = 3'd4;
    end else if (|mag[20:14]) begin
      n_delta = 3'd3;
    end else if (|mag[13:7]) begin
      n_delta = 3'd2;
    end else begin
      n_delta = 3'd1;
    end
  end

  // 12*octave = 8*octave + 4*octave
  assign key_sum = {1'b0, in_octave, 3'b000} + {2'b00, in_octave, 2'b00}
                 + {5'b00000, in_pitch_class};

  always_comb begin
    q_desc.n_delta = n_delta;
    q_desc.delta   = mag;
    q_desc.status  = (in_mode ? mneu_pkg::StatusOn : mneu_pkg::StatusOff)
                   | {4'b0000, in_channel};
    q_desc.key     = key_sum[7:0];
    q_desc.vel     = in_velocity;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

[hw/rtl/mneu_queue.sv]
// ----------------------------------------------------------------------------
// mneu_queue
// Small FIFO of classified events between front and back.
// ----------------------------------------------------------------------------
module mneu_queue #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mneu_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output mneu_pkg::desc_t q_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mneu_pkg::desc_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full    = (count_r == CntW'(Depth));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

[hw/rtl/mneu_back.sv]
// ----------------------------------------------------------------------------
// mneu_back
// Serializes one queued event into VLQ delta, status, key and velocity beats.
// ----------------------------------------------------------------------------
module mneu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  mneu_pkg::desc_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_byte
);

  mneu_pkg::state_t             state_r, state_nxt;
  logic [mneu_pkg::NDeltaW-1:0] dcnt_r, dcnt_nxt;
  logic [mneu_pkg::DeltaW-1:0]  sh_r, sh_nxt;
  logic [7:0]                   status_r, status_nxt;
  logic [7:0]                   key_r, key_nxt;
  logic [6:0]                   vel_r, vel_nxt;
  logic [mneu_pkg::DeltaW-1:0]  aligned;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_free;
  logic       load;
  logic       emit;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign out_free = !out_valid_r || out_ready;

  // put the first group at the top of the shifter
  always_comb begin
    unique case (q_data.n_delta)
      3'd4:    aligned = q_data.delta;
      3'd3:    aligned = {q_data.delta[20:0], 7'b0};
      3'd2:    aligned = {q_data.delta[13:0], 14'b0};
      default: aligned = {q_data.delta[6:0], 21'b0};
    endcase
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    dcnt_nxt   = dcnt_r;
    sh_nxt     = sh_r;
    status_nxt = status_r;
    key_nxt    = key_r;
    vel_nxt    = vel_r;
    load       = 1'b0;
    unique case (state_r)
      mneu_pkg::ST_IDLE: begin
        load = q_valid;
      end
      mneu_pkg::ST_DELTA: begin
        if (out_free) begin
          sh_nxt   = {sh_r[mneu_pkg::DeltaW-mneu_pkg::GroupW-1:0],
                      {mneu_pkg::GroupW{1'b0}}};
          dcnt_nxt = dcnt_r - 1'b1;
          if (dcnt_r == 3'd1) begin
            state_nxt = mneu_pkg::ST_STATUS;
          end
        end
      end
      mneu_pkg::ST_STATUS: begin
        if (out_free) begin
          state_nxt = mneu_pkg::ST_KEY;
        end
      end
      mneu_pkg::ST_KEY: begin
        if (out_free) begin
          state_nxt = mneu_pkg::ST_VEL;
        end
      end
      mneu_pkg::ST_VEL: begin
        if (out_free) begin
          state_nxt = mneu_pkg::ST_IDLE;
          load      = q_valid;
        end
      end
      default: begin
        state_nxt = mneu_pkg::ST_IDLE;
      end
    endcase
    if (load) begin
      state_nxt  = (q_data.n_delta != '0) ? mneu_pkg::ST_DELTA : mneu_pkg::ST_STATUS;
      dcnt_nxt   = q_data.n_delta;
      sh_nxt     = aligned;
      status_nxt = q_data.status;
      key_nxt    = q_data.key;
      vel_nxt    = q_data.vel;
    end
  end

  // outputs
  always_comb begin
    emit     = 1'b1;
    cur_byte = '0;
    cur_last = 1'b0;
    unique case (state_r)
      mneu_pkg::ST_DELTA: begin
        cur_byte = {(dcnt_r != 3'd1), sh_r[mneu_pkg::DeltaW-1 -: mneu_pkg::GroupW]};
      end
      mneu_pkg::ST_STATUS: begin
        cur_byte = status_r;
      end
      mneu_pkg::ST_KEY: begin
        cur_byte = key_r;
      end
      mneu_pkg::ST_VEL: begin
        cur_byte = {1'b0, vel_r};
        cur_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = emit;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = cur_last;
    end
  end

  assign q_pop         = load;
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mneu_pkg::ST_IDLE;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    status_r   <= status_nxt;
    key_r      <= key_nxt;
    vel_r      <= vel_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= 3'(mneu_pkg::MaxDelta))
    else $error("delta count out of range");

  a_delta_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mneu_pkg::ST_DELTA) |-> (dcnt_r != '0))
    else $error("delta state with no bytes left");

  a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == mneu_pkg::ST_IDLE
               || (state_r == mneu_pkg::ST_VEL && out_free)))
    else $error("event popped mid-serialization");

  a_last_follows_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mneu_pkg::ST_VEL && out_free) |=> (out_valid_r && out_last_r))
    else $error("velocity beat not flagged last");

endmodule

[hw/rtl/midi_note_event_encoder_unit.sv]
// ----------------------------------------------------------------------------
// midi_note_event_encoder_unit
// Encodes note-on/off events into standard MIDI track-event bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one note event per beat.
// Output channel (out_valid/out_ready): one byte per beat, in order: delta
// time as a big-endian VLQ of 1 to 4 bytes (none when the delta is negative),
// status, key, velocity. out_last_byte marks the velocity byte.
// Throughput: one byte per cycle from the serializer unless the receiver
// stalls. An event is 3 to 7 bytes (delta bytes + 3); queued events follow
// with no gap. First byte path: FIFO, serializer state, output register.
// The front classifies events into a QueueDepth-entry FIFO; in_ready drops
// only when that FIFO is full. When the receiver stalls, the output register
// holds its byte, the serializer waits, and the FIFO absorbs new events.
// Reset (rst_n low, synchronous) empties the FIFO and drops out_valid.
// ----------------------------------------------------------------------------
module midi_note_event_encoder_unit #(
  parameter int QueueDepth = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [28:0] in_delta_ticks,
  input  logic [3:0]         in_channel,
  input  logic [4:0]         in_octave,
  input  logic [3:0]         in_pitch_class,
  input  logic [6:0]         in_velocity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_byte
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  mneu_pkg::desc_t push_desc;
  mneu_pkg::desc_t head_desc;

  mneu_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_delta_ticks (in_delta_ticks),
    .in_channel     (in_channel),
    .in_octave      (in_octave),
    .in_pitch_class (in_pitch_class),
    .in_velocity    (in_velocity),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_desc         (push_desc)
  );

  mneu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (head_desc)
  );

  mneu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (head_desc),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

[bench/tb_midi_note_event_encoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_note_event_encoder_unit
// Self-checking bench for the MIDI note event encoder. A directed table walks
// the delta length boundaries, negative deltas, both event kinds and key
// wrap. Random events follow with random idle gaps on both channels, one
// long output stall and pauses that drain the encoder. Each output byte is
// compared against golden table bytes or an in-bench byte encoder.
// ----------------------------------------------------------------------------
module tb_midi_note_event_encoder_unit;

  localparam logic ModeOff       = 1'b0;
  localparam logic ModeOn        = 1'b1;
  localparam int   KeysPerOctave = 12;
  localparam int   RandomEvents  = 400;
  localparam int   LongHold      = 80;
  localparam int   MaxReports    = 30;

  typedef struct {
    logic        mode;
    logic [28:0] delta;
    logic [3:0]  channel;
    logic [4:0]  octave;
    logic [3:0]  pitch;
    logic [6:0]  velocity;
  } note_event_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } track_byte_t;

  typedef struct {
    note_event_t ev;
    int          gold_n;
    logic [55:0] gold;
  } note_row_t;

  typedef enum logic [2:0] {
    SPAN_RAW,
    SPAN_NEG,
    SPAN_ONE,
    SPAN_TWO,
    SPAN_THREE,
    SPAN_FOUR
  } delta_span_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic signed [28:0] in_delta_ticks;
  logic [3:0]         in_channel;
  logic [4:0]         in_octave;
  logic [3:0]         in_pitch_class;
  logic [6:0]         in_velocity;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_byte;
  logic               out_last_byte;

  track_byte_t pending_bytes[$];
  note_row_t   note_table[$];
  int          errors;
  int          events_sent;
  int          neg_delta_events;
  int          long_delta_events;
  int          bytes_checked;
  logic        steady_run;
  logic        long_hold_req;

  midi_note_event_encoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_delta_ticks (in_delta_ticks),
    .in_channel     (in_channel),
    .in_octave      (in_octave),
    .in_pitch_class (in_pitch_class),
    .in_velocity    (in_velocity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxReports) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic void queue_byte(input logic [7:0] value, input logic last);
    pending_bytes = {pending_bytes, track_byte_t'{value, last}};
  endfunction

  // VLQ delta (big-endian, 7 bits per byte), then status, key, velocity
  function automatic void encode_note_event(input note_event_t ev);
    logic [27:0] rest;
    logic [6:0]  grp[4];
    int          cnt;
    logic [7:0]  key;
    if (!ev.delta[28]) begin
      rest = ev.delta[27:0];
      cnt  = 0;
      do begin
        grp[cnt] = rest[6:0];
        cnt++;
        rest = rest >> 7;
      end while (rest != 0 && cnt < 4);
      for (int i = cnt - 1; i >= 0; i--) begin
        queue_byte({i != 0, grp[i]}, 1'b0);
      end
    end
    queue_byte((ev.mode ? mneu_pkg::StatusOn : mneu_pkg::StatusOff) |
               {4'h0, ev.channel}, 1'b0);
    key = 8'(KeysPerOctave * int'(ev.octave) + int'(ev.pitch));
    queue_byte(key, 1'b0);
    queue_byte({1'b0, ev.velocity}, 1'b1);
  endfunction

  function automatic void add_row(input logic mode, input logic [28:0] delta,
                                  input int ch, input int oct, input int pc,
                                  input int vel, input int gold_n,
                                  input logic [55:0] gold);
    note_row_t row;
    row.ev.mode     = mode;
    row.ev.delta    = delta;
    row.ev.channel  = 4'(ch);
    row.ev.octave   = 5'(oct);
    row.ev.pitch    = 4'(pc);
    row.ev.velocity = 7'(vel);
    row.gold_n      = gold_n;
    row.gold        = gold;
    note_table      = {note_table, row};
  endfunction

  function automatic note_event_t make_random_note();
    note_event_t ev;
    delta_span_t span;
    span = delta_span_t'($urandom_range(0, 5));
    case (span)
      SPAN_RAW:   ev.delta = 29'($urandom);
      SPAN_NEG:   ev.delta = {1'b1, 28'($urandom)};
      SPAN_ONE:   ev.delta = 29'($urandom_range(0, 127));
      SPAN_TWO:   ev.delta = 29'($urandom_range(128, 16383));
      SPAN_THREE: ev.delta = 29'($urandom_range(16384, 2097151));
      default:    ev.delta = 29'($urandom_range(2097152, 268435455));
    endcase
    ev.mode     = $urandom_range(0, 1) ? ModeOn : ModeOff;
    ev.channel  = 4'($urandom_range(0, 15));
    ev.octave   = 5'($urandom_range(0, 31));
    ev.pitch    = 4'($urandom_range(0, 15));
    ev.velocity = 7'($urandom_range(0, 127));
    return ev;
  endfunction

  // gold_n == 0 means the expected bytes come from encode_note_event
  task automatic send_note(input note_event_t ev, input int gap, input int gold_n,
                           input logic [55:0] gold);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode        = ev.mode;
    in_delta_ticks = ev.delta;
    in_channel     = ev.channel;
    in_octave      = ev.octave;
    in_pitch_class = ev.pitch;
    in_velocity    = ev.velocity;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gold_n == 0) begin
      encode_note_event(ev);
    end else begin
      for (int i = gold_n - 1; i >= 0; i--) begin
        queue_byte(gold[8*i +: 8], i == 0);
      end
    end
    events_sent++;
    if (ev.delta[28]) neg_delta_events++;
    else if (ev.delta[27:21] != 0) long_delta_events++;
    @(negedge clk);
  endtask

  task automatic drain_encoder();
    in_valid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_byte();
    track_byte_t want;
    bytes_checked++;
    if (pending_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, out_last_byte));
      return;
    end
    want = pending_bytes.pop_front();
    if (out_byte !== want.value) begin
      report_mismatch($sformatf("byte %02h, expected %02h", out_byte, want.value));
    end
    if (out_last_byte !== want.last) begin
      report_mismatch($sformatf("last flag %0b, expected %0b on byte %02h",
                                out_last_byte, want.last, want.value));
    end
  endtask

  // byte sink: random stalls, one long hold on request
  initial begin : byte_sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LongHold;
      end else begin
        stall = steady_run ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_byte();
      @(negedge clk);
    end
  end

  initial begin : event_source
    int gap;
    errors            = 0;
    events_sent       = 0;
    neg_delta_events  = 0;
    long_delta_events = 0;
    bytes_checked     = 0;
    steady_run        = 1'b0;
    long_hold_req     = 1'b0;
    in_valid          = 1'b0;
    in_mode           = ModeOff;
    in_delta_ticks    = '0;
    in_channel        = '0;
    in_octave         = '0;
    in_pitch_class    = '0;
    in_velocity       = '0;
    rst_n             = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(ModeOn,  29'h0000000,  0,  0,  0,   0, 4, 56'h00_90_00_00);
    add_row(ModeOff, 29'h1FFFFFFF, 15, 0,  0, 127, 3, 56'h8F_00_7F);
    add_row(ModeOn,  29'h000007F,  1,  5,  0,  64, 4, 56'h7F_91_3C_40);
    add_row(ModeOff, 29'h0000080,  2,  5,  1,   1, 5, 56'h81_00_82_3D_01);
    add_row(ModeOn,  29'h0FFFFFFF, 15, 21, 11, 127, 7, 56'hFF_FF_FF_7F_9F_07_7F);
    add_row(ModeOff, 29'h10000000, 0,  0,  0,   0, 3, 56'h80_00_00);
    add_row(ModeOn,  29'h0000000,  0,  31, 15, 85, 4, 56'h00_90_83_55);
    add_row(ModeOn,  29'h0003FFF,  3,  4,  2,  90, 0, '0);
    add_row(ModeOff, 29'h0004000,  4,  6,  3,  33, 0, '0);
    add_row(ModeOn,  29'h01FFFFF,  5,  7,  4,  17, 0, '0);
    add_row(ModeOff, 29'h0200000,  6,  8,  5, 100, 0, '0);
    add_row(ModeOn,  29'h0000001,  7,  21, 4,  12, 0, '0);
    add_row(ModeOn,  29'h0AAAAAAA, 8,  10, 7, 127, 0, '0);
    add_row(ModeOff, 29'h15555555, 9,  0,  15,  2, 0, '0);
    add_row(ModeOn,  29'h05555555, 10, 16, 12, 42, 0, '0);
    add_row(ModeOff, 29'h0001234,  11, 30, 13, 77, 0, '0);
    add_row(ModeOn,  29'h1F000000, 12, 1,  14, 63, 0, '0);
    add_row(ModeOff, 29'h0000000,  13, 20, 9,  99, 0, '0);
    add_row(ModeOn,  29'h00FEDCB,  14, 11, 10,  8, 0, '0);
    add_row(ModeOff, 29'h0FFFFFFF, 15, 31, 15, 127, 0, '0);

    foreach (note_table[i]) begin
      gap = (i < 5) ? 0 : $urandom_range(0, 9);
      send_note(note_table[i].ev, gap, note_table[i].gold_n, note_table[i].gold);
    end
    drain_encoder();

    for (int k = 0; k < RandomEvents; k++) begin
      if (k % 70 == 0) steady_run = ($urandom_range(0, 2) == 0);
      if (k == 150) long_hold_req = 1'b1;
      if (k == 300) drain_encoder();
      gap = (steady_run || (k >= 150 && k < 162)) ? 0 : $urandom_range(0, 9);
      send_note(make_random_note(), gap, 0, '0);
    end
    in_valid = 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));
    end

    $display("Encoded %0d note events (%0d negative delta, %0d four-byte delta), %0d bytes",
             events_sent, neg_delta_events, long_delta_events, bytes_checked);
    $display("Covered idle gaps, back-to-back runs, a long stall and key wrap; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
